// ----- hw/rtl/i2ctrf_pkg.sv -----
// shared types and codes for the i2c target register file
// no dependencies; imported by every module of the block
package i2ctrf_pkg;

    // bus event codes
    localparam logic [2:0] OP_ADDR_WRITE = 3'd0;
    localparam logic [2:0] OP_ADDR_READ  = 3'd1;
    localparam logic [2:0] OP_BYTE_RX    = 3'd2;
    localparam logic [2:0] OP_BYTE_REQ   = 3'd3;
    localparam logic [2:0] OP_STOP       = 3'd4;
    localparam logic [2:0] OP_BUS_ERROR  = 3'd5;

    // transfer phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_ADDRESSED = 3'd1;
    localparam logic [2:0] PH_PTR_SET   = 3'd2;
    localparam logic [2:0] PH_READING   = 3'd3;
    localparam logic [2:0] PH_WRITING   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_VERSION_ADDR  = 2'd0;
    localparam logic [1:0] CFG_IDENT_ADDR    = 2'd1;
    localparam logic [1:0] CFG_VERSION_VALUE = 2'd2;
    localparam logic [1:0] CFG_IDENT_VALUE   = 2'd3;

    localparam logic [7:0] VERSION_ADDR_RST  = 8'h00;
    localparam logic [7:0] IDENT_ADDR_RST    = 8'h01;
    localparam logic [7:0] VERSION_VALUE_RST = 8'h11;
    localparam logic [7:0] IDENT_VALUE_RST   = 8'h5A;

    typedef struct packed {
        logic [7:0] version_addr;
        logic [7:0] ident_addr;
        logic [7:0] version_value;
        logic [7:0] ident_value;
    } cfg_t;

    typedef struct packed {
        logic       we;
        logic [7:0] wdata;
    } wr_req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] phase;
        logic [7:0] transfer_count;
    } result_t;

endpackage

// ----- hw/rtl/i2ctrf_store.sv -----
// register store: one write port, one prefetch read port with registered data
// per-entry valid bits make unwritten entries read as their own index; uses i2ctrf_pkg
module i2ctrf_store #(
    parameter int REG_COUNT = 256,
    parameter int IDX_W     = $clog2(REG_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2ctrf_pkg::wr_req_t  wr,
    input  logic [IDX_W-1:0]     widx,
    input  logic [IDX_W-1:0]     ridx,
    output logic [7:0]           rd_byte
);
    import i2ctrf_pkg::*;

    logic [7:0]           store_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           rdata_reg;
    logic                 rvld_reg;
    logic [IDX_W-1:0]     ridx_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            store_mem[widx] <= wr.wdata;
        end
        rdata_reg <= store_mem[ridx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
            ridx_reg  <= '0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[widx] <= 1'b1;
            end
            rvld_reg <= valid_reg[ridx];
            ridx_reg <= ridx;
        end
    end

    // never-written entries hold their reset contents, the index itself
    assign rd_byte = rvld_reg ? rdata_reg : 8'(ridx_reg);

    // the write always lands beside the prefetched entry, so no bypass is needed
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (widx != ridx))
        else $error("store write and prefetch read hit the same entry");

endmodule

// ----- hw/rtl/i2ctrf_ctrl.sv -----
// transfer phase controller, register pointer and transfer counter
// drives the store write and prefetch index; uses i2ctrf_pkg
module i2ctrf_ctrl #(
    parameter int REG_COUNT = 256,
    parameter int IDX_W     = $clog2(REG_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [2:0]           operation,
    input  logic [7:0]           rx_byte,
    input  i2ctrf_pkg::cfg_t     cfg,
    input  logic [7:0]           rd_byte,
    output i2ctrf_pkg::wr_req_t  wr,
    output logic [IDX_W-1:0]     widx,
    output logic [IDX_W-1:0]     ridx,
    output i2ctrf_pkg::result_t  res
);
    import i2ctrf_pkg::*;

    // rounded-up reciprocal of the store depth, exact quotient for any 8-bit pointer
    localparam int RECIP = (65536 + REG_COUNT - 1) / REG_COUNT;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       ptr_reg, ptr_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       read_byte;
    logic [IDX_W-1:0] idx_adv;
    logic             do_read;
    logic             do_write;

    // pointer modulo the store depth by reciprocal multiplication
    function automatic logic [IDX_W-1:0] store_index(input logic [7:0] v);
        logic [23:0] prod;
        logic [15:0] back;
        logic [7:0]  rem;
        prod = {16'd0, v} * 24'(RECIP);
        back = {8'd0, prod[23:16]} * 16'(REG_COUNT);
        rem  = v - back[7:0];
        return rem[IDX_W-1:0];
    endfunction

    // version address wins over ident when both match
    assign read_byte = (ptr_reg == cfg.version_addr) ? cfg.version_value :
                       (ptr_reg == cfg.ident_addr)   ? cfg.ident_value   : rd_byte;

    // pointer wrap from 255 restarts the store index at zero
    assign idx_adv = ((ptr_reg == 8'hFF) || (idx_reg == IDX_W'(REG_COUNT - 1)))
                   ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        do_read    = 1'b0;
        do_write   = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (operation == OP_ADDR_WRITE)
                begin
                    phase_next = PH_ADDRESSED;
                end
            end
            PH_ADDRESSED:
            begin
                if (operation == OP_BYTE_RX)
                begin
                    phase_next = PH_PTR_SET;
                    ptr_next   = rx_byte;
                    idx_next   = store_index(rx_byte);
                end
            end
            PH_PTR_SET:
            begin
                if (operation == OP_ADDR_READ)
                begin
                    phase_next = PH_READING;
                    do_read    = 1'b1;
                end
                else if (operation == OP_BYTE_RX)
                begin
                    phase_next = PH_WRITING;
                    do_write   = 1'b1;
                end
            end
            PH_WRITING:
            begin
                if (operation == OP_BYTE_RX)
                begin
                    do_write = 1'b1;
                end
                else if (operation == OP_STOP)
                begin
                    phase_next = PH_IDLE;
                end
                else if (operation == OP_BUS_ERROR)
                begin
                    phase_next = PH_IDLE;
                    count_next = count_reg + 1'b1;
                end
            end
            PH_READING:
            begin
                if (operation == OP_BYTE_REQ)
                begin
                    do_read = 1'b1;
                end
                else if ((operation == OP_STOP) || (operation == OP_BUS_ERROR))
                begin
                    phase_next = PH_IDLE;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (do_read || do_write)
        begin
            ptr_next = ptr_reg + 1'b1;
            idx_next = idx_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ptr_reg   <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    assign wr.we    = accept && do_write;
    assign wr.wdata = rx_byte;
    assign widx     = idx_reg;
    // prefetch the entry the next item will see
    assign ridx     = accept ? idx_next : idx_reg;

    assign res.tx_valid       = do_read;
    assign res.tx_byte        = do_read ? read_byte : 8'h00;
    assign res.phase          = phase_next;
    assign res.transfer_count = count_next;

    a_tx_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.tx_valid) |-> (phase_next == PH_READING))
        else $error("byte sent outside a read");

    a_count_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (phase_reg == PH_IDLE))
        else $error("transfer counter moved without ending the transfer");

    a_ptr_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg != $past(ptr_reg)) |-> $past(accept))
        else $error("pointer moved with no request taken");

endmodule

// ----- hw/rtl/i2c_target_register_file.sv -----
// i2c target register file: stream front end, configuration registers, output register
// a result is registered and presented in the cycle after its request is accepted
// one request per cycle unless back-pressured; store read one request ahead at pointer
// reset: asynchronous, active low; phase idle, pointer and counter zero, store reads
// as its own index through per-entry valid bits, so no clearing pass is run
// depends on i2ctrf_pkg, i2ctrf_ctrl and i2ctrf_store
module i2c_target_register_file #(
    parameter int REG_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] tx_byte, [10:8] phase, [18:11] transfer_count
    output logic [0:0]  m_tuser,   // [0] tx_valid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import i2ctrf_pkg::*;

    localparam int IDX_W = $clog2(REG_COUNT);

    cfg_t             cfg_reg;
    wr_req_t          wr;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] ridx;
    logic [7:0]       rd_byte;
    result_t          res;
    result_t          out_reg;
    logic             out_vld_reg;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.version_addr  <= VERSION_ADDR_RST;
            cfg_reg.ident_addr    <= IDENT_ADDR_RST;
            cfg_reg.version_value <= VERSION_VALUE_RST;
            cfg_reg.ident_value   <= IDENT_VALUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_VERSION_ADDR:  cfg_reg.version_addr  <= cfg_wdata;
                CFG_IDENT_ADDR:    cfg_reg.ident_addr    <= cfg_wdata;
                CFG_VERSION_VALUE: cfg_reg.version_value <= cfg_wdata;
                CFG_IDENT_VALUE:   cfg_reg.ident_value   <= cfg_wdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2ctrf_ctrl #(
        .REG_COUNT (REG_COUNT),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (s_tuser),
        .rx_byte   (s_tdata),
        .cfg       (cfg_reg),
        .rd_byte   (rd_byte),
        .wr        (wr),
        .widx      (widx),
        .ridx      (ridx),
        .res       (res)
    );

    i2ctrf_store #(
        .REG_COUNT (REG_COUNT),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .widx    (widx),
        .ridx    (ridx),
        .rd_byte (rd_byte)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.tx_valid;
    assign m_tdata  = {5'd0, out_reg.transfer_count, out_reg.phase, out_reg.tx_byte};

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

endmodule

// ----- sim/i2ctrf_transfer_checker.sv -----
// checker for the i2c target register file: watches the request, result and config ports,
// predicts each result from its own copy of the transfer state and compares field by field
// depends on i2ctrf_pkg
`timescale 1ns / 1ps

module i2ctrf_transfer_checker #(
    parameter int REG_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_tuser,   // [2:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] tx_byte, [10:8] phase, [18:11] transfer_count
    input  logic [0:0]  m_tuser,   // [0] tx_valid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    output int          errors,
    output int          pending
);
    import i2ctrf_pkg::*;

    cfg_t       cfg;
    logic [2:0] phase_q;
    logic [7:0] reg_ptr;
    logic [7:0] xfer_count;
    logic [7:0] reg_mem [REG_COUNT];

    result_t    expected_results [$];
    result_t    predicted;
    result_t    want;
    int         i;

    // fixed addresses win over the store; version wins when both match
    function automatic logic [7:0] fetch_and_advance();
        logic [7:0] p;
        p = reg_ptr;
        reg_ptr = p + 8'd1;
        if (p == cfg.version_addr)
            return cfg.version_value;
        if (p == cfg.ident_addr)
            return cfg.ident_value;
        return reg_mem[p % REG_COUNT];
    endfunction

    task automatic store_and_advance(input logic [7:0] v);
        reg_mem[reg_ptr % REG_COUNT] = v;
        reg_ptr = reg_ptr + 8'd1;
    endtask

    task automatic apply_bus_event(input logic [2:0] op, input logic [7:0] rx,
                                   output result_t res);
        res = '0;
        case (phase_q)
            PH_IDLE:
            begin
                if (op == OP_ADDR_WRITE)
                    phase_q = PH_ADDRESSED;
            end
            PH_ADDRESSED:
            begin
                if (op == OP_BYTE_RX)
                begin
                    reg_ptr = rx;
                    phase_q = PH_PTR_SET;
                end
            end
            PH_PTR_SET:
            begin
                if (op == OP_ADDR_READ)
                begin
                    phase_q = PH_READING;
                    res.tx_byte = fetch_and_advance();
                    res.tx_valid = 1'b1;
                end
                else if (op == OP_BYTE_RX)
                begin
                    phase_q = PH_WRITING;
                    store_and_advance(rx);
                end
            end
            PH_WRITING:
            begin
                if (op == OP_BYTE_RX)
                    store_and_advance(rx);
                else if (op == OP_STOP)
                    phase_q = PH_IDLE;
                else if (op == OP_BUS_ERROR)
                begin
                    phase_q = PH_IDLE;
                    xfer_count = xfer_count + 8'd1;
                end
            end
            PH_READING:
            begin
                if (op == OP_BYTE_REQ)
                begin
                    res.tx_byte = fetch_and_advance();
                    res.tx_valid = 1'b1;
                end
                else if (op == OP_STOP || op == OP_BUS_ERROR)
                begin
                    phase_q = PH_IDLE;
                    xfer_count = xfer_count + 8'd1;
                end
            end
            default:
                phase_q = PH_IDLE;
        endcase
        res.phase = phase_q;
        res.transfer_count = xfer_count;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch: expected %02h, actual %02h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.version_addr  = VERSION_ADDR_RST;
            cfg.ident_addr    = IDENT_ADDR_RST;
            cfg.version_value = VERSION_VALUE_RST;
            cfg.ident_value   = IDENT_VALUE_RST;
            phase_q    = PH_IDLE;
            reg_ptr    = 8'd0;
            xfer_count = 8'd0;
            for (i = 0; i < REG_COUNT; i++)
                reg_mem[i] = i[7:0];
            expected_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_VERSION_ADDR:  cfg.version_addr  = cfg_wdata;
                    CFG_IDENT_ADDR:    cfg.ident_addr    = cfg_wdata;
                    CFG_VERSION_VALUE: cfg.version_value = cfg_wdata;
                    CFG_IDENT_VALUE:   cfg.ident_value   = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                apply_bus_event(s_tuser, s_tdata, predicted);
                expected_results.push_back(predicted);
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected result: expected none, actual %06h / %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, m_tuser[0]});
                    check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
                    check_field("phase", {5'd0, want.phase}, {5'd0, m_tdata[10:8]});
                    check_field("transfer_count", want.transfer_count, m_tdata[18:11]);
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

// ----- sim/tb_i2c_target_register_file.sv -----
// testbench top for the i2c target register file: drives bus event requests, config writes
// and result back-pressure; the checker alongside does prediction and comparison
// depends on i2ctrf_pkg, i2c_target_register_file and i2ctrf_transfer_checker
`timescale 1ns / 1ps

module tb_i2c_target_register_file;
    import i2ctrf_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 1550;
    localparam int PHASE_COUNT  = 7;

    // operation codes the block does not define
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    int          errors;
    int          pending;
    int          sent_count = 0;
    int          stall_cycles = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int          hold_req = 0;
    int          hold_done = 0;
    logic [7:0]  cur_version_addr = VERSION_ADDR_RST;
    logic [7:0]  cur_ident_addr = IDENT_ADDR_RST;

    i2c_target_register_file dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    i2ctrf_transfer_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // nothing accepted on either side for too long means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[i2c_target_register_file] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // result side: random back-pressure, quiet stretches, and a long hold-off whenever one is requested
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_done != hold_req)
            begin
                hold_done = hold_req;
                gap = HOLD_CYCLES;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                gap = rx_quiet ? 0 : $urandom_range(0, 18);
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] rand_op();
        return 3'($urandom_range(0, 7));
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_event(input logic [2:0] op, input logic [7:0] rx);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] va, input logic [7:0] ia,
                                  input logic [7:0] vv, input logic [7:0] iv);
        settle();
        cfg_write(CFG_VERSION_ADDR, va);
        cfg_write(CFG_IDENT_ADDR, ia);
        cfg_write(CFG_VERSION_VALUE, vv);
        cfg_write(CFG_IDENT_VALUE, iv);
        cfg_we <= 1'b0;
        cur_version_addr = va;
        cur_ident_addr = ia;
    endtask

    // pointers mostly land just below the fixed addresses or the wrap point
    function automatic logic [7:0] pick_pointer();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'(cur_version_addr - $urandom_range(0, 3));
        if (r < 6)
            return 8'(cur_ident_addr - $urandom_range(0, 3));
        if (r == 6)
            return 8'(8'hFF - $urandom_range(0, 3));
        return rand_byte();
    endfunction

    function automatic int burst_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic random_transfer();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        n = burst_len();
        if (kind < 12)
            send_event(rand_op(), rand_byte());
        else if (kind < 60)
        begin
            send_event(OP_ADDR_WRITE, rand_byte());
            send_event(OP_BYTE_RX, pick_pointer());
            send_event(OP_ADDR_READ, rand_byte());
            repeat (n)
            begin
                // occasional stray request breaks the sequence
                if ($urandom_range(0, 19) == 0)
                    send_event(rand_op(), rand_byte());
                else
                    send_event(OP_BYTE_REQ, rand_byte());
            end
            send_event(($urandom_range(0, 4) == 0) ? OP_BUS_ERROR : OP_STOP,
                       rand_byte());
        end
        else
        begin
            send_event(OP_ADDR_WRITE, rand_byte());
            send_event(OP_BYTE_RX, pick_pointer());
            repeat (n)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_event(rand_op(), rand_byte());
                else
                    send_event(OP_BYTE_RX, rand_byte());
            end
            send_event(($urandom_range(0, 9) < 4) ? OP_BUS_ERROR : OP_STOP,
                       rand_byte());
        end
    endtask

    initial
    begin
        int p;
        int phase_end;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = 3'd0;
        cfg_we    = 1'b0;
        cfg_addr  = 2'd0;
        cfg_wdata = 8'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // undefined codes and out-of-place events while idle
        send_event(OP_UNUSED_7, 8'hFF);
        send_event(OP_UNUSED_6, 8'h00);
        send_event(OP_BUS_ERROR, 8'h55);
        send_event(OP_ADDR_READ, 8'hAA);
        // write across the pointer wrap, with events that the addressed and writing phases ignore
        send_event(OP_ADDR_WRITE, 8'h00);
        send_event(OP_BYTE_REQ, 8'h00);
        send_event(OP_BYTE_RX, 8'hFF);
        send_event(OP_BYTE_RX, 8'h00);
        send_event(OP_BYTE_RX, 8'hA5);
        send_event(OP_ADDR_READ, 8'h00);
        send_event(OP_STOP, 8'h00);
        // read through the wrap: the store, then both fixed addresses, the first over a written entry
        send_event(OP_ADDR_WRITE, 8'h00);
        send_event(OP_BYTE_RX, 8'hFF);
        send_event(OP_ADDR_READ, 8'h00);
        send_event(OP_BYTE_REQ, 8'h00);
        send_event(OP_BYTE_REQ, 8'h00);
        send_event(OP_BYTE_REQ, 8'h00);
        send_event(OP_BYTE_RX, 8'h33);
        send_event(OP_STOP, 8'h00);
        // aborted write, then a read of what it left behind aborted too
        send_event(OP_ADDR_WRITE, 8'h00);
        send_event(OP_BYTE_RX, 8'h10);
        send_event(OP_BYTE_RX, 8'h7E);
        send_event(OP_BUS_ERROR, 8'h00);
        send_event(OP_ADDR_WRITE, 8'h00);
        send_event(OP_BYTE_RX, 8'h10);
        send_event(OP_ADDR_READ, 8'h00);
        send_event(OP_BUS_ERROR, 8'h00);

        for (p = 1; p <= PHASE_COUNT; p++)
        begin
            case (p)
                1: apply_settings(8'h40, 8'h40, 8'hFF, 8'h00);
                2: apply_settings(8'hFF, 8'h00, 8'h00, 8'hFF);
                3: apply_settings(8'h00, 8'hFF, 8'hFF, 8'hFF);
                default: apply_settings(rand_byte(), rand_byte(), rand_byte(), rand_byte());
            endcase
            if (p == 1 || p == 4)
                hold_req = hold_req + 1;
            phase_end = (p == PHASE_COUNT) ? ITEM_TARGET : sent_count + 215;
            while (sent_count < phase_end)
                random_transfer();
        end

        settle();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("[i2c_target_register_file] OK");
        else
            $display("[i2c_target_register_file] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/i2ctrf_pkg.sv
hw/rtl/i2ctrf_store.sv
hw/rtl/i2ctrf_ctrl.sv
hw/rtl/i2c_target_register_file.sv
sim/i2ctrf_transfer_checker.sv
sim/tb_i2c_target_register_file.sv
